[design/ech_pkg.sv]
// Shared types, constants and the log2 table for the histogram coloring block.
// No dependencies.
package ech_pkg;

  localparam int unsigned MAX_ITER  = 256;
  localparam int unsigned ADDR_W    = 8;
  localparam int unsigned CNT_W     = 9;
  localparam int unsigned SUM_W     = 17;
  localparam int unsigned LOG_W     = 27;
  localparam int unsigned PROD_W    = SUM_W + LOG_W;
  localparam logic [SUM_W-1:0] SUM_MAX   = 17'h1FFFF;
  localparam logic [7:0]       ALPHA     = 8'hFF;
  localparam logic [7:0]       TOP_LEVEL = 8'd255;

  typedef logic [LOG_W-1:0] log_tab_t [256];

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_WRD,
    ST_WWR,
    ST_PIX,
    ST_SRCH,
    ST_HOLD
  } state_t;

  // log2(g) with 24 fraction bits, by repeated squaring of the mantissa
  function automatic logic [LOG_W-1:0] fixed_log2(int unsigned g);
    logic [63:0] y;
    logic [2:0]  n;
    logic [23:0] frac;
    n = 3'd0;
    frac = 24'd0;
    for (int k = 1; k < 8; k++) begin
      if ((g >> k) != 0) n = 3'(k);
    end
    y = 64'(g) << (31 - int'(n));
    for (int i = 0; i < 24; i++) begin
      frac = {frac[22:0], 1'b0};
      y = (y * y) >> 31;
      if (y[63:32] != 32'd0) begin
        frac[0] = 1'b1;
        y = y >> 1;
      end
    end
    return {n, frac};
  endfunction

  function automatic log_tab_t build_log_tab();
    log_tab_t t;
    t[0] = '0;
    for (int g = 1; g < 256; g++) begin
      t[g] = fixed_log2(g);
    end
    return t;
  endfunction

  localparam log_tab_t LOG_TAB = build_log_tab();

endpackage

[design/ech_in_if.sv]
// Input channel: escape counts with pass function and end-of-pass mark.
// Depends on ech_pkg.
interface ech_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [ech_pkg::CNT_W-1:0]   escape_count;
  logic                        last_pixel;
  modport source (output valid, func, escape_count, last_pixel, input ready);
  modport sink   (input valid, func, escape_count, last_pixel, output ready);
endinterface

[design/ech_out_if.sv]
// Result channel: colored pixel words with end-of-frame mark.
// No package dependencies.
interface ech_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_rgba;
  logic        frame_done;
  modport source (output valid, pixel_rgba, frame_done, input ready);
  modport sink   (input valid, pixel_rgba, frame_done, output ready);
endinterface

[design/escape_count_histogram_coloring.sv]
// Histogram-equalized coloring of escape counts; top level and only module.
// Depends on ech_pkg, ech_in_if, ech_out_if.
//
// channel   | dir | payload                              | transaction
// ----------+-----+--------------------------------------+------------------------------
// in_ch     | in  | func, escape_count[8:0], last_pixel  | valid & ready at rising clk
// out_ch    | out | pixel_rgba[31:0], frame_done         | valid & ready at rising clk
//
// Sequence: func 0 transaction reads the histogram bin, then writes it back;
//   the one with last_pixel adds a running-sum walk (read + write per bin).
// func 1 transaction reads the bin, then runs up to 8 binary-search steps, latches
//   the level and holds it for output; each search step uses the 17x27 multiplier
//   once. Never-escaped, empty or not-yet-summed pixels skip the search.
// Reset: synchronous active-low rst_n clears FSM, bin valid bits, total, flag and
//   output valid. Bin storage itself is not reset; an invalid bin reads as zero.
// Stalls: a finished pixel waits in ST_HOLD while the output register is full
//   and not taken; in_ch.ready is high only in ST_IDLE.
module escape_count_histogram_coloring (
  input  logic      clk,
  input  logic      rst_n,
  ech_in_if.sink    in_ch,
  ech_out_if.source out_ch
);

  // histogram memory: tallies, then running sums after the walk
  logic [ech_pkg::SUM_W-1:0]  mem [ech_pkg::MAX_ITER];
  logic [ech_pkg::SUM_W-1:0]  rd_q;
  logic [ech_pkg::ADDR_W-1:0] rd_addr;
  logic                       we;
  logic [ech_pkg::ADDR_W-1:0] wa;
  logic [ech_pkg::SUM_W-1:0]  wd;

  // a bin with its valid bit clear reads as zero; clearing the frame clears these
  logic [ech_pkg::MAX_ITER-1:0] valid_r;

  ech_pkg::state_t state_r, state_nxt;

  logic [ech_pkg::ADDR_W-1:0] addr_r;
  logic                       cnt_hi_r;   // count at or above MAX_ITER: never escaped
  logic                       last_r;
  logic [ech_pkg::ADDR_W-1:0] idx_r;
  logic [ech_pkg::SUM_W-1:0]  run_r;
  logic [ech_pkg::SUM_W-1:0]  total_r;
  logic                       cum_r;
  logic [ech_pkg::PROD_W-1:0] rhs_r;
  logic [7:0]                 lo_r, hi_r, green_r;
  logic                       out_valid_r;
  logic [31:0]                pixel_r;
  logic                       done_r;

  logic [ech_pkg::SUM_W-1:0]  bin_val;
  logic [ech_pkg::SUM_W:0]    sum_wide;
  logic [ech_pkg::SUM_W-1:0]  sum_sat;
  logic [8:0]                 mid_wide;
  logic [7:0]                 mid;
  logic [ech_pkg::PROD_W-1:0] lhs;
  logic                       accept_in;
  logic                       out_free;

  assign bin_val   = valid_r[addr_r] ? rd_q : '0;
  assign sum_wide  = {1'b0, run_r} + {1'b0, (valid_r[idx_r] ? rd_q : '0)};
  assign sum_sat   = sum_wide[ech_pkg::SUM_W] ? ech_pkg::SUM_MAX : sum_wide[ech_pkg::SUM_W-1:0];
  assign mid_wide  = ({1'b0, lo_r} + {1'b0, hi_r} + 9'd1) >> 1;
  assign mid       = mid_wide[7:0];
  assign lhs       = ech_pkg::PROD_W'(total_r) * ech_pkg::PROD_W'(ech_pkg::LOG_TAB[mid]);
  assign accept_in = in_ch.valid && in_ch.ready;
  assign out_free  = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_rgba = pixel_r;
  assign out_ch.frame_done = done_r;

  // next state and memory port control
  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    rd_addr     = in_ch.escape_count[ech_pkg::ADDR_W-1:0];
    we          = 1'b0;
    wa          = addr_r;
    wd          = bin_val + ech_pkg::SUM_W'(1);
    case (state_r)
      ech_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          state_nxt = in_ch.func ? ech_pkg::ST_PIX : ech_pkg::ST_ACC;
        end
      end
      ech_pkg::ST_ACC: begin
        // saturating tally; never-escaped pixels are not counted
        we        = !cnt_hi_r && (bin_val < ech_pkg::SUM_MAX);
        state_nxt = last_r ? ech_pkg::ST_WRD : ech_pkg::ST_IDLE;
      end
      ech_pkg::ST_WRD: begin
        rd_addr   = idx_r;
        state_nxt = ech_pkg::ST_WWR;
      end
      ech_pkg::ST_WWR: begin
        we        = 1'b1;
        wa        = idx_r;
        wd        = sum_sat;
        state_nxt = (idx_r == ech_pkg::ADDR_W'(ech_pkg::MAX_ITER - 1)) ?
                    ech_pkg::ST_IDLE : ech_pkg::ST_WRD;
      end
      ech_pkg::ST_PIX: begin
        if (!cum_r || cnt_hi_r || total_r == '0) begin
          state_nxt = ech_pkg::ST_HOLD;
        end else begin
          state_nxt = ech_pkg::ST_SRCH;
        end
      end
      ech_pkg::ST_SRCH: begin
        if (lo_r == hi_r) state_nxt = ech_pkg::ST_HOLD;
      end
      ech_pkg::ST_HOLD: begin
        if (out_free) state_nxt = ech_pkg::ST_IDLE;
      end
      default: state_nxt = ech_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ech_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state: valid bits, total, cumulative flag, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      total_r     <= '0;
      cum_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // load a finished pixel, else drop the one just taken
      if (state_r == ech_pkg::ST_HOLD && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ech_pkg::ST_IDLE: begin
          // new frame while sums are live: start over
          if (accept_in && !in_ch.func && cum_r) begin
            valid_r <= '0;
            total_r <= '0;
            cum_r   <= 1'b0;
          end
        end
        ech_pkg::ST_ACC: begin
          if (we) valid_r[addr_r] <= 1'b1;
        end
        ech_pkg::ST_WWR: begin
          valid_r[idx_r] <= 1'b1;
          if (idx_r == ech_pkg::ADDR_W'(ech_pkg::MAX_ITER - 1)) begin
            total_r <= sum_sat;
            cum_r   <= 1'b1;
          end
        end
        ech_pkg::ST_HOLD: begin
          if (out_free && last_r) begin
            valid_r <= '0;
            total_r <= '0;
            cum_r   <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ech_pkg::ST_IDLE: begin
        if (accept_in) begin
          addr_r   <= in_ch.escape_count[ech_pkg::ADDR_W-1:0];
          cnt_hi_r <= in_ch.escape_count[ech_pkg::CNT_W-1];
          last_r   <= in_ch.last_pixel;
        end
      end
      ech_pkg::ST_ACC: begin
        idx_r <= '0;
        run_r <= '0;
      end
      ech_pkg::ST_WWR: begin
        run_r <= sum_sat;
        idx_r <= idx_r + 8'd1;
      end
      ech_pkg::ST_PIX: begin
        green_r <= 8'd0;
        lo_r    <= 8'd1;
        hi_r    <= ech_pkg::TOP_LEVEL;
        rhs_r   <= ech_pkg::PROD_W'(bin_val) *
                   ech_pkg::PROD_W'(ech_pkg::LOG_TAB[ech_pkg::TOP_LEVEL]);
      end
      ech_pkg::ST_SRCH: begin
        // largest g with total*L[g] <= c*L[255]
        if (lo_r == hi_r) begin
          green_r <= lo_r;
        end else if (lhs <= rhs_r) begin
          lo_r <= mid;
        end else begin
          hi_r <= mid - 8'd1;
        end
      end
      ech_pkg::ST_HOLD: begin
        if (out_free) begin
          pixel_r <= {8'h00, green_r, 8'h00, ech_pkg::ALPHA};
          done_r  <= last_r;
        end
      end
      default: ;
    endcase
  end

  // search bounds never cross
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ech_pkg::ST_SRCH |-> lo_r <= hi_r)
    else $error("search bounds crossed");

  // running sums exist only when every bin has been written by the walk
  assert property (@(posedge clk) disable iff (!rst_n)
    cum_r |-> (&valid_r))
    else $error("cumulative flag set with unwritten bins");

  // the last walk step always leaves the table cumulative
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ech_pkg::ST_WWR &&
     idx_r == ech_pkg::ADDR_W'(ech_pkg::MAX_ITER - 1)) |=> cum_r)
    else $error("walk finished without setting cumulative flag");

endmodule
